// File: rtl/bf16_add_sub_macros.svh
// Assertion macros for the bf16 add/sub block.
// Used by the top level; no other dependencies.
`ifndef BF16_ADD_SUB_MACROS_SVH
`define BF16_ADD_SUB_MACROS_SVH
`define BAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/bas_pkg.sv
// Package for the bf16 add/sub block: stage payload types and constants.
// No dependencies.
package bas_pkg;
   localparam logic [15:0] QNAN_BITS = 16'h7FC0;
   localparam logic [7:0]  EXP_MAX   = 8'hFF;

   // stage 1 -> 2: unpacked and ordered operands
   typedef struct packed {
      logic       early;      // result already known (special operand or gap above 8)
      logic [15:0] early_val;
      logic       sign_big;
      logic       sign_small;
      logic [7:0] exp_big;
      logic [7:0] man_big;
      logic [7:0] man_small;
      logic [3:0] gap;
   } s1_type;

   // stage 2 -> 3: raw sum or difference
   typedef struct packed {
      logic       early;
      logic [15:0] early_val;
      logic       sign;
      logic [7:0] exp;
      logic [8:0] sum;
      logic       is_sub;
   } s2_type;
endpackage

// File: rtl/bas_norm.sv
// Normalise stage logic for the bf16 add/sub block: leading-one search and pack.
// Depends on bas_pkg.
module bas_norm (
   input  bas_pkg::s2_type s2,
   output logic [15:0]     result
);
   import bas_pkg::*;
   logic [3:0] lz;
   logic [8:0] ext_exp;
   logic [7:0] shifted;
   always_comb begin
      lz = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (s2.sum[i]) begin
            lz = 4'(7 - i);
         end
      end
      shifted = s2.sum[7:0] << lz;
      ext_exp = {1'b0, s2.exp};
      result  = '0;
      if (s2.early) begin
         result = s2.early_val;
      end else if (!s2.is_sub) begin
         if (s2.sum[8]) begin
            if (ext_exp + 9'd1 >= {1'b0, EXP_MAX}) begin
               result = {s2.sign, EXP_MAX, 7'd0};
            end else begin
               result = {s2.sign, s2.exp + 8'd1, s2.sum[7:1]};
            end
         end else begin
            result = {s2.sign, s2.exp, s2.sum[6:0]};
         end
      end else begin
         if (s2.sum[7:0] == 8'd0 || ext_exp <= {5'd0, lz}) begin
            result = '0;
         end else begin
            result = {s2.sign, s2.exp - {4'd0, lz}, shifted[6:0]};
         end
      end
   end
endmodule

// File: rtl/bf16_add_sub.sv
// bf16_add_sub: bfloat16 add/subtract, three register stages.
// A req beat is registered into v1_ff, then v2_ff, then v3_ff, which drives rsp_valid;
// one beat per cycle while rsp_stall does not hold the output.
// A stall freezes the whole pipe; nothing is lost or repeated.
// Synchronous active-high reset clears the valid bits only.
// Depends on bas_pkg, bas_norm and bf16_add_sub_macros.svh.
`include "bf16_add_sub_macros.svh"
module bf16_add_sub (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_sum_bits
);
   import bas_pkg::*;
   logic v1_ff, v2_ff, v3_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic [15:0] res_ff, res_in;
   logic adv;

   assign adv       = !(v3_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = v3_ff;
   assign rsp_sum_bits = res_ff;

   // stage 1: specials, ordering
   logic [15:0] a, b;
   logic sa, sb;
   logic [7:0] ea, eb, ma, mb;
   logic [8:0] diff;
   always_comb begin
      a  = req_operand_a;
      b  = req_operand_b ^ {req_opcode, 15'd0};
      sa = a[15];
      sb = b[15];
      ea = a[14:7];
      eb = b[14:7];
      ma = {(ea != 8'd0), a[6:0]};
      mb = {(eb != 8'd0), b[6:0]};
      diff = {1'b0, ea} - {1'b0, eb};
      s1_in = '0;
      if (ea == EXP_MAX) begin
         s1_in.early = 1'b1;
         if (a[6:0] != 7'd0) s1_in.early_val = a;
         else if (eb == EXP_MAX)
            s1_in.early_val = (b[6:0] != 7'd0 || sa == sb) ? b : QNAN_BITS;
         else s1_in.early_val = a;
      end else if (eb == EXP_MAX) begin
         s1_in.early = 1'b1;
         s1_in.early_val = b;
      end else if (a[14:0] == 15'd0) begin
         s1_in.early = 1'b1;
         s1_in.early_val = b;
      end else if (b[14:0] == 15'd0) begin
         s1_in.early = 1'b1;
         s1_in.early_val = a;
      end else if (!diff[8]) begin
         s1_in.early     = diff > 9'd8;
         s1_in.early_val = a;
         s1_in.sign_big  = sa;
         s1_in.sign_small = sb;
         s1_in.exp_big   = ea;
         s1_in.man_big   = ma;
         s1_in.man_small = mb;
         s1_in.gap       = diff[3:0];
      end else begin
         s1_in.early     = (9'd0 - diff) > 9'd8;
         s1_in.early_val = b;
         s1_in.sign_big  = sb;
         s1_in.sign_small = sa;
         s1_in.exp_big   = eb;
         s1_in.man_big   = mb;
         s1_in.man_small = ma;
         s1_in.gap       = 4'(9'd0 - diff);
      end
   end

   // stage 2: align and add or subtract
   logic [7:0] al;
   always_comb begin
      al = s1_ff.man_small >> s1_ff.gap;
      s2_in.early     = s1_ff.early;
      s2_in.early_val = s1_ff.early_val;
      s2_in.exp       = s1_ff.exp_big;
      s2_in.is_sub    = s1_ff.sign_big != s1_ff.sign_small;
      s2_in.sign      = s1_ff.sign_big;
      s2_in.sum       = {1'b0, s1_ff.man_big} + {1'b0, al};
      if (s2_in.is_sub) begin
         if (s1_ff.man_big >= al) begin
            s2_in.sum = {1'b0, s1_ff.man_big - al};
         end else begin
            s2_in.sum  = {1'b0, al - s1_ff.man_big};
            s2_in.sign = s1_ff.sign_small;
         end
      end
   end

   // stage 3: normalise
   bas_norm u_norm (.s2(s2_ff), .result(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         res_ff <= res_in;
      end
   end

   `BAS_ASSERT_NEXT(a_valid_flow, clock, reset, req_valid && !req_stall, v1_ff, "beat lost")
   `BAS_ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sum_bits), "held beat changed")
   `BAS_ASSERT_IMPL(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall, "stall without output block")
endmodule

// File: dv/tb_bf16_add_sub.sv
// Testbench for bf16_add_sub: directed and random add/subtract beats checked
// against a bit-exact predictor in the bench. Depends on the RTL only.
`timescale 1ns / 100ps
module tb_bf16_add_sub;
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_ADD;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_sum_bits;

   logic [15:0] sum_queue[$];
   int          errors = 0;
   bit          idle_on = 1'b1;
   int          hold_cycles = 0;
   int          hold_asked = 0;
   int          hold_seen = 0;

   bf16_add_sub u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] bf16_sum(logic [15:0] a, logic [15:0] b);
      logic       sa, sb, rs;
      int         ea, eb, re, gap;
      logic [8:0] ma, mb, rm;
      sa = a[15]; sb = b[15];
      ea = int'(a[14:7]); eb = int'(b[14:7]);
      ma = {2'b0, a[6:0]}; mb = {2'b0, b[6:0]};
      if (ea == 255) begin
         if (ma != 0) return a;
         if (eb == 255) return (mb != 0 || sa == sb) ? b : 16'h7FC0;
         return a;
      end
      if (eb == 255) return b;
      if (ea == 0 && ma == 0) return b;
      if (eb == 0 && mb == 0) return a;
      if (ea != 0) ma[7] = 1'b1;
      if (eb != 0) mb[7] = 1'b1;
      gap = ea - eb;
      re = (gap < 0) ? eb : ea;
      if (gap > 8) return a;
      if (gap < -8) return b;
      if (gap > 0) mb = mb >> gap;
      if (gap < 0) ma = ma >> (-gap);
      if (sa == sb) begin
         rs = sa;
         rm = ma + mb;
         if (rm[8]) begin
            rm = rm >> 1;
            re++;
            if (re >= 255) return {rs, 15'h7F80};
         end
      end else begin
         if (ma >= mb) begin rs = sa; rm = ma - mb; end
         else begin rs = sb; rm = mb - ma; end
         if (rm == 0) return 16'h0000;
         while (!rm[7]) begin
            rm = rm << 1;
            re--;
            if (re <= 0) return 16'h0000;
         end
      end
      return {rs, re[7:0], rm[6:0]};
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // called at a falling edge; leaves valid high, the next call or the caller drops it
   task automatic send_beat(logic op, logic [15:0] a, logic [15:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sum_queue.push_back(bf16_sum(a, op == OP_SUB ? b ^ 16'h8000 : b));
      @(negedge clock);
   endtask

   // receiver stall: long hold when asked, otherwise random bursts
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         rsp_stall <= 1'b1;
         hold_cycles <= 39;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (idle_on && !rsp_stall && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sum_queue.size() == 0) begin
            report_mismatch("unexpected beat", rsp_sum_bits, 16'h0000);
         end else begin
            logic [15:0] want;
            want = sum_queue.pop_front();
            if (rsp_sum_bits !== want) report_mismatch("sum_bits", rsp_sum_bits, want);
         end
      end
   end

   function automatic logic [15:0] rand_bf16();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 9))
         0: v[14:7] = 8'hFF;
         1: v[14:7] = 8'h00;
         2: v[14:0] = 15'h0;
         3: v[14:7] = 8'($urandom_range(250, 254));
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic [15:0] pats[12] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0,
                                16'h7F81, 16'h3F80, 16'hBF80, 16'h7F7F, 16'h0001,
                                16'h007F, 16'hFFFF};
      foreach (pats[i]) send_beat(i[0] ? OP_SUB : OP_ADD, pats[i], pats[(i * 5) % 12]);
      send_beat(OP_SUB, 16'h7F80, 16'h7F80);
      send_beat(OP_ADD, 16'h7F80, 16'hFF80);
      send_beat(OP_SUB, 16'h3F80, 16'h3F80);
      send_beat(OP_ADD, 16'h4000, 16'h3B00);
      send_beat(OP_ADD, 16'h4000, 16'h3B80);
      send_beat(OP_ADD, 16'h7F7F, 16'h7F7F);
      send_beat(OP_SUB, 16'h0080, 16'h0081);
      send_beat(OP_SUB, 16'h3F81, 16'h3F80);
   endtask

   task automatic test_random(int count);
      repeat (count) send_beat(1'($urandom_range(0, 1)), rand_bf16(), rand_bf16());
   endtask

   task automatic test_near_values(int count);
      logic [15:0] a, b;
      repeat (count) begin
         a = 16'($urandom);
         b = a ^ 16'($urandom_range(0, 1) << 15);
         b[14:7] = 8'(a[14:7] + $urandom_range(0, 2));
         b[6:0] = 7'($urandom);
         send_beat(1'($urandom_range(0, 1)), a, b);
      end
   endtask

   task automatic test_backpressure();
      hold_asked++;
      test_random(20);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_random(600);
      test_near_values(300);
      idle_on = 1'b0;
      test_random(200);
      req_valid <= 1'b0;
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end
endmodule
